@@ rtl/salsa20_stream_cipher_top_assert.svh @@
// Assertion macros used by the Salsa20 stream cipher top level.
`ifndef SALSA20_STREAM_CIPHER_TOP_ASSERT_SVH
`define SALSA20_STREAM_CIPHER_TOP_ASSERT_SVH

// Check that the consequent holds in the same cycle as the antecedent.
`define S20_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Check that the consequent holds in the cycle after the antecedent.
`define S20_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/s20_pkg.sv @@
// Types, constants and round functions of the Salsa20 stream cipher.
package s20_pkg;

  localparam int WORD_W = 32;
  localparam int ADDR_W = 6;
  localparam int DATA_W = 64;

  typedef logic [WORD_W-1:0] word_t;
  typedef logic [15:0][WORD_W-1:0] block_t;
  typedef logic [3:0][WORD_W-1:0] quad_t;

  // "expand 32-byte k" as four little-endian words.
  localparam word_t SIGMA_0 = 32'h6170_7865;
  localparam word_t SIGMA_1 = 32'h3320_646e;
  localparam word_t SIGMA_2 = 32'h7962_2d32;
  localparam word_t SIGMA_3 = 32'h6b20_6574;

  // Register indexes; each register is 64 bits at byte address 8*index.
  typedef enum logic [2:0] {
    REG_KEY_0_63    = 3'd0,
    REG_KEY_64_127  = 3'd1,
    REG_KEY_128_191 = 3'd2,
    REG_KEY_192_255 = 3'd3,
    REG_NONCE       = 3'd4
  } reg_idx_e;

  typedef struct packed {
    logic [63:0] key_0_63;
    logic [63:0] key_64_127;
    logic [63:0] key_128_191;
    logic [63:0] key_192_255;
    logic [63:0] nonce;
  } cfg_t;

  // Requests from the byte datapath to the keystream generator.
  typedef struct packed {
    logic        take;
    logic        abort;
    logic [63:0] need_ctr;
  } gen_cmd_t;

  // Status of the prefetched keystream block.
  typedef struct packed {
    logic        valid;
    logic [63:0] ctr;
  } pf_stat_t;

  function automatic word_t rotl(word_t v, int unsigned s);
    return (v << s) | (v >> (WORD_W - s));
  endfunction

  function automatic quad_t quarter(word_t a, word_t b, word_t c, word_t d);
    quad_t r;
    r[1] = b ^ rotl(a + d, 7);
    r[2] = c ^ rotl(r[1] + a, 9);
    r[3] = d ^ rotl(r[2] + r[1], 13);
    r[0] = a ^ rotl(r[3] + r[2], 18);
    return r;
  endfunction

  function automatic block_t apply_qr(block_t w, logic [3:0] a, logic [3:0] b,
                                      logic [3:0] c, logic [3:0] d);
    block_t r;
    quad_t  q;
    r = w;
    q = quarter(w[a], w[b], w[c], w[d]);
    r[a] = q[0];
    r[b] = q[1];
    r[c] = q[2];
    r[d] = q[3];
    return r;
  endfunction

  // The four quarter rounds of a column round touch disjoint words.
  function automatic block_t column_round(block_t w);
    block_t r;
    r = apply_qr(w, 4'd0, 4'd4, 4'd8, 4'd12);
    r = apply_qr(r, 4'd5, 4'd9, 4'd13, 4'd1);
    r = apply_qr(r, 4'd10, 4'd14, 4'd2, 4'd6);
    r = apply_qr(r, 4'd15, 4'd3, 4'd7, 4'd11);
    return r;
  endfunction

  function automatic block_t row_round(block_t w);
    block_t r;
    r = apply_qr(w, 4'd0, 4'd1, 4'd2, 4'd3);
    r = apply_qr(r, 4'd5, 4'd6, 4'd7, 4'd4);
    r = apply_qr(r, 4'd10, 4'd11, 4'd8, 4'd9);
    r = apply_qr(r, 4'd15, 4'd12, 4'd13, 4'd14);
    return r;
  endfunction

  function automatic block_t init_block(cfg_t cfg, logic [63:0] ctr);
    block_t r;
    r[0]  = SIGMA_0;
    r[1]  = cfg.key_0_63[31:0];
    r[2]  = cfg.key_0_63[63:32];
    r[3]  = cfg.key_64_127[31:0];
    r[4]  = cfg.key_64_127[63:32];
    r[5]  = SIGMA_1;
    r[6]  = cfg.nonce[31:0];
    r[7]  = cfg.nonce[63:32];
    r[8]  = ctr[31:0];
    r[9]  = ctr[63:32];
    r[10] = SIGMA_2;
    r[11] = cfg.key_128_191[31:0];
    r[12] = cfg.key_128_191[63:32];
    r[13] = cfg.key_192_255[31:0];
    r[14] = cfg.key_192_255[63:32];
    r[15] = SIGMA_3;
    return r;
  endfunction

  function automatic block_t add_blocks(block_t a, block_t b);
    block_t r;
    for (int i = 0; i < 16; i++) begin
      r[i] = a[i] + b[i];
    end
    return r;
  endfunction

endpackage

@@ rtl/s20_cfg_regs.sv @@
// APB-style register bank holding the key and nonce.
module s20_cfg_regs (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [s20_pkg::ADDR_W-1:0]   paddr,
  input  logic [s20_pkg::DATA_W-1:0]   pwdata,
  output logic [s20_pkg::DATA_W-1:0]   prdata,
  output logic                         pready,
  output s20_pkg::cfg_t                cfg_o,
  output logic                         wr_o
);
  import s20_pkg::*;

  cfg_t     cfg_q, cfg_d;
  reg_idx_e idx;
  logic     wr;

  assign pready = 1'b1;
  assign idx    = reg_idx_e'(paddr[ADDR_W-1:3]);
  assign wr     = psel & penable & pwrite;

  // Register write decode; unmapped indexes are ignored.
  always_comb begin
    cfg_d = cfg_q;
    if (wr) begin
      case (idx)
        REG_KEY_0_63:    cfg_d.key_0_63    = pwdata;
        REG_KEY_64_127:  cfg_d.key_64_127  = pwdata;
        REG_KEY_128_191: cfg_d.key_128_191 = pwdata;
        REG_KEY_192_255: cfg_d.key_192_255 = pwdata;
        REG_NONCE:       cfg_d.nonce       = pwdata;
        default:         cfg_d = cfg_q;
      endcase
    end
  end

  // Read mux.
  always_comb begin
    case (idx)
      REG_KEY_0_63:    prdata = cfg_q.key_0_63;
      REG_KEY_64_127:  prdata = cfg_q.key_64_127;
      REG_KEY_128_191: prdata = cfg_q.key_128_191;
      REG_KEY_192_255: prdata = cfg_q.key_192_255;
      REG_NONCE:       prdata = cfg_q.nonce;
      default:         prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;
  assign wr_o  = wr;

endmodule

@@ rtl/s20_core.sv @@
// Iterative Salsa20 block generator with a one-block prefetch buffer.
module s20_core #(
  parameter int ROUND_COUNT = 20
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  s20_pkg::cfg_t       cfg_i,
  input  s20_pkg::gen_cmd_t   cmd_i,
  output s20_pkg::pf_stat_t   stat_o,
  output s20_pkg::block_t     blk_o
);
  import s20_pkg::*;

  // An odd round count rounds up to a whole double round.
  localparam int RoundsDone = 2 * ((ROUND_COUNT + 1) / 2);
  localparam int RndW       = $clog2(RoundsDone + 1);

  logic            busy_q, busy_d;
  logic            pf_valid_q, pf_valid_d;
  logic [63:0]     ctr_q, ctr_d;
  logic [RndW-1:0] rnd_q, rnd_d;
  block_t          w_q, w_d;
  block_t          pf_q, pf_d;
  logic            hit, start, done;

  // Start a block whenever the generator is idle and the buffer does not hold the one needed next.
  assign hit   = pf_valid_q && (ctr_q == cmd_i.need_ctr);
  assign start = !busy_q && !hit;
  assign done  = busy_q && (rnd_q == RndW'(RoundsDone));

  // Control next state; a register write drops any block built on old key.
  always_comb begin
    busy_d     = busy_q;
    pf_valid_d = pf_valid_q;
    ctr_d      = ctr_q;
    rnd_d      = rnd_q;
    if (cmd_i.take) begin
      pf_valid_d = 1'b0;
    end
    if (start) begin
      busy_d     = 1'b1;
      pf_valid_d = 1'b0;
      ctr_d      = cmd_i.need_ctr;
      rnd_d      = '0;
    end else if (done) begin
      busy_d     = 1'b0;
      pf_valid_d = 1'b1;
    end else if (busy_q) begin
      rnd_d = rnd_q + RndW'(1);
    end
    if (cmd_i.abort) begin
      busy_d     = 1'b0;
      pf_valid_d = 1'b0;
    end
  end

  // Working state: load, then one column or row round per cycle, then the final add into the prefetch buffer.
  always_comb begin
    w_d  = w_q;
    pf_d = pf_q;
    if (start) begin
      w_d = init_block(cfg_i, cmd_i.need_ctr);
    end else if (done) begin
      pf_d = add_blocks(w_q, init_block(cfg_i, ctr_q));
    end else if (busy_q) begin
      w_d = rnd_q[0] ? row_round(w_q) : column_round(w_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q     <= 1'b0;
      pf_valid_q <= 1'b0;
      ctr_q      <= '0;
      rnd_q      <= '0;
    end else begin
      busy_q     <= busy_d;
      pf_valid_q <= pf_valid_d;
      ctr_q      <= ctr_d;
      rnd_q      <= rnd_d;
    end
  end

  always_ff @(posedge clk_i) begin
    w_q  <= w_d;
    pf_q <= pf_d;
  end

  assign stat_o.valid = pf_valid_q;
  assign stat_o.ctr   = ctr_q;
  assign blk_o        = pf_q;

endmodule

@@ rtl/salsa20_stream_cipher_top.sv @@
// Salsa20 stream cipher top level: byte datapath, key registers, block generator.
//
// Usage: each input word carries data_byte_i, restart_i and chunk_last_i on a
// valid/stall channel; each output word carries out_byte_o (data XOR
// keystream) and chunk_last_out_o. Key and nonce are written through the APB
// port at byte addresses 0, 8, 16, 24 (key) and 32 (nonce), 64 bits each.
// An accepted word is registered and appears on the output in the next cycle.
// Throughput: one word per cycle while the keystream block is at hand and
// the receiver does not stall. The generator builds the next block ahead,
// one column or row round per cycle; the 64 bytes of a block hide that
// build. A word that opens a block the buffer does not hold (after
// chunk_last, after a key write, or right after reset) waits on in_stall_o
// until the block is built. A restart word that finds the generator busy on
// another block waits for that build first.
// Reset clears the block counter and byte position; the first word builds
// block zero. When the receiver stalls, the output register holds its word
// and in_stall_o rises until the word is taken.
`include "salsa20_stream_cipher_top_assert.svh"

module salsa20_stream_cipher_top #(
  parameter int ROUND_COUNT = 20
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [s20_pkg::ADDR_W-1:0]  paddr,
  input  logic [s20_pkg::DATA_W-1:0]  pwdata,
  output logic [s20_pkg::DATA_W-1:0]  prdata,
  output logic                        pready,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [7:0]                  data_byte_i,
  input  logic                        restart_i,
  input  logic                        chunk_last_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [7:0]                  out_byte_o,
  output logic                        chunk_last_out_o
);
  import s20_pkg::*;

  cfg_t        cfg;
  logic        cfg_wr;
  gen_cmd_t    gen_cmd;
  pf_stat_t    pf_stat;
  block_t      pf_blk;

  logic [63:0] ctr_q, ctr_d;
  logic [5:0]  pos_q, pos_d;
  block_t      ks_q;
  logic        out_valid_q, out_valid_d;
  logic [7:0]  out_byte_q;
  logic        out_last_q;

  logic [63:0] eff_ctr;
  logic [5:0]  eff_pos;
  logic        new_blk, blk_ready, in_acc;
  logic [511:0] blk_flat;
  logic [7:0]  ks_byte;

  s20_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg),
    .wr_o    (cfg_wr)
  );

  s20_core #(
    .ROUND_COUNT (ROUND_COUNT)
  ) u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .cmd_i  (gen_cmd),
    .stat_o (pf_stat),
    .blk_o  (pf_blk)
  );

  // Restart clears counter and position before the byte is used.
  assign eff_ctr   = restart_i ? 64'd0 : ctr_q;
  assign eff_pos   = restart_i ? 6'd0 : pos_q;
  assign new_blk   = (eff_pos == 6'd0);
  assign blk_ready = !new_blk || (pf_stat.valid && (pf_stat.ctr == eff_ctr));

  // Handshake: the output register frees up in the cycle its word is taken.
  assign in_stall_o = (out_valid_q && out_stall_i) || !blk_ready;
  assign in_acc     = in_valid_i && !in_stall_o;

  // Tell the generator which block is wanted next.
  assign gen_cmd.take     = in_acc && new_blk;
  assign gen_cmd.abort    = cfg_wr;
  assign gen_cmd.need_ctr = (in_valid_i && restart_i) ? 64'd0 : ctr_q;

  // Keystream byte p sits at bits 8p..8p+7 of the flattened block.
  assign blk_flat = new_blk ? pf_blk : ks_q;
  assign ks_byte  = blk_flat[{eff_pos, 3'b000} +: 8];

  // Counter and position update for an accepted word.
  always_comb begin
    ctr_d = ctr_q;
    pos_d = pos_q;
    if (in_acc) begin
      ctr_d = new_blk ? (eff_ctr + 64'd1) : eff_ctr;
      pos_d = chunk_last_i ? 6'd0 : (eff_pos + 6'd1);
    end
  end

  // Output register valid.
  always_comb begin
    if (in_acc) begin
      out_valid_d = 1'b1;
    end else if (out_stall_i) begin
      out_valid_d = out_valid_q;
    end else begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctr_q       <= '0;
      pos_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      ctr_q       <= ctr_d;
      pos_q       <= pos_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers: current keystream block and output word.
  always_ff @(posedge clk_i) begin
    if (in_acc && new_blk) begin
      ks_q <= pf_blk;
    end
    if (in_acc) begin
      out_byte_q <= data_byte_i ^ ks_byte;
      out_last_q <= chunk_last_i;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign out_byte_o       = out_byte_q;
  assign chunk_last_out_o = out_last_q;

  `S20_ASSERT_NEXT(a_accept_gives_word, in_acc, out_valid_o, "accepted word not presented")
  `S20_ASSERT_NEXT(a_last_clears_pos, in_acc && chunk_last_i, pos_q == 6'd0, "position not cleared")
  `S20_ASSERT_NEXT(a_restart_counter, in_acc && restart_i, ctr_q == 64'd1, "restart counter wrong")
  `S20_ASSERT_SAME(a_block_matches, in_acc && new_blk, pf_stat.valid && pf_stat.ctr == eff_ctr, "stale block used")

endmodule

@@ dv/salsa20_stream_cipher_top_tb.sv @@
`timescale 1ns / 100ps
// Self-checking testbench of the Salsa20 stream cipher top level with its own keystream predictor.
module salsa20_stream_cipher_top_tb;
  import s20_pkg::*;

  localparam int CIPHER_ROUNDS = 20;
  localparam int HOLD_AT_WORD  = 300;
  localparam int HOLD_CYCLES   = 400;
  localparam int IDLE_LIMIT    = 4000;
  localparam int DRAIN_CYCLES  = 30;

  typedef logic [15:0][31:0] ks_block_t;

  typedef struct packed {
    logic [7:0] data;
    logic       restart;
    logic       last;
  } plain_word_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } cipher_word_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;
  logic              in_valid_i = 1'b0;
  logic              in_stall_o;
  logic [7:0]        data_byte_i = '0;
  logic              restart_i = 1'b0;
  logic              chunk_last_i = 1'b0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  logic [7:0]        out_byte_o;
  logic              chunk_last_out_o;

  // Predictor state: configuration copy, block counter, position and current block.
  logic [63:0]  key_reg [4];
  logic [63:0]  nonce_reg;
  logic [63:0]  blk_ctr;
  logic [5:0]   blk_pos;
  ks_block_t    ks_words;

  plain_word_t  plain_q [$];
  cipher_word_t cipher_q [$];
  plain_word_t  next_word;
  cipher_word_t due_word;

  int words_queued = 0;
  int words_sent   = 0;
  int words_taken  = 0;
  int errors       = 0;
  int idle_cycles  = 0;
  int tx_wait      = 0;
  int rx_wait      = 0;
  bit tx_gaps_on   = 1'b1;
  bit rx_gaps_on   = 1'b1;

  salsa20_stream_cipher_top #(
    .ROUND_COUNT(CIPHER_ROUNDS)
  ) u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .data_byte_i     (data_byte_i),
    .restart_i       (restart_i),
    .chunk_last_i    (chunk_last_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .out_byte_o      (out_byte_o),
    .chunk_last_out_o(chunk_last_out_o)
  );

  always #1 clk_i = ~clk_i;

  // The upper half of the doubled word shifted left is the left rotation.
  function automatic logic [31:0] rot_left32(logic [31:0] v, int unsigned s);
    logic [63:0] both;
    both = {v, v} << s;
    return both[63:32];
  endfunction

  function automatic ks_block_t mix_quarter(ks_block_t x, int a, int b, int c, int d);
    x[b] = x[b] ^ rot_left32(x[a] + x[d], 7);
    x[c] = x[c] ^ rot_left32(x[b] + x[a], 9);
    x[d] = x[d] ^ rot_left32(x[c] + x[b], 13);
    x[a] = x[a] ^ rot_left32(x[d] + x[c], 18);
    return x;
  endfunction

  // Build one 64-byte keystream block from the current key, nonce and counter.
  function automatic ks_block_t salsa_core(logic [63:0] ctr);
    ks_block_t init_w;
    ks_block_t x;
    init_w[0]  = SIGMA_0;
    init_w[1]  = key_reg[0][31:0];
    init_w[2]  = key_reg[0][63:32];
    init_w[3]  = key_reg[1][31:0];
    init_w[4]  = key_reg[1][63:32];
    init_w[5]  = SIGMA_1;
    init_w[6]  = nonce_reg[31:0];
    init_w[7]  = nonce_reg[63:32];
    init_w[8]  = ctr[31:0];
    init_w[9]  = ctr[63:32];
    init_w[10] = SIGMA_2;
    init_w[11] = key_reg[2][31:0];
    init_w[12] = key_reg[2][63:32];
    init_w[13] = key_reg[3][31:0];
    init_w[14] = key_reg[3][63:32];
    init_w[15] = SIGMA_3;
    x = init_w;
    // An odd round count still runs a whole double round.
    for (int r = 0; r < CIPHER_ROUNDS; r += 2) begin
      x = mix_quarter(x, 0, 4, 8, 12);
      x = mix_quarter(x, 5, 9, 13, 1);
      x = mix_quarter(x, 10, 14, 2, 6);
      x = mix_quarter(x, 15, 3, 7, 11);
      x = mix_quarter(x, 0, 1, 2, 3);
      x = mix_quarter(x, 5, 6, 7, 4);
      x = mix_quarter(x, 10, 11, 8, 9);
      x = mix_quarter(x, 15, 12, 13, 14);
    end
    for (int i = 0; i < 16; i++) begin
      x[i] = x[i] + init_w[i];
    end
    return x;
  endfunction

  // Advance the cipher state by one word and queue the ciphertext it must produce.
  function automatic void encrypt_byte(plain_word_t w);
    logic [31:0]  ks_w;
    logic [7:0]   ks;
    cipher_word_t c;
    if (w.restart) begin
      blk_ctr = '0;
      blk_pos = '0;
    end
    if (blk_pos == 6'd0) begin
      ks_words = salsa_core(blk_ctr);
      blk_ctr  = blk_ctr + 64'd1;
    end
    ks_w    = ks_words[blk_pos[5:2]];
    ks      = ks_w[8*blk_pos[1:0] +: 8];
    blk_pos = w.last ? 6'd0 : blk_pos + 6'd1;
    c.data  = w.data ^ ks;
    c.last  = w.last;
    cipher_q.push_back(c);
  endfunction

  function automatic void queue_word(logic [7:0] d, logic rs, logic lst);
    plain_word_t w;
    w.data    = d;
    w.restart = rs;
    w.last    = lst;
    plain_q.push_back(w);
    words_queued++;
  endfunction

  // Write one register, read it back, and mirror it into the predictor.
  task automatic write_reg(input reg_idx_e idx, input logic [63:0] value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (prdata !== value) begin
      $error("prdata: expected %016h, got %016h", value, prdata);
      errors++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    if (idx == REG_NONCE) begin
      nonce_reg = value;
    end else begin
      key_reg[int'(idx)] = value;
    end
  endtask

  // Fill every register: 0 all zeros, 1 all ones, otherwise random.
  task automatic write_all(input int fill);
    logic [63:0] value;
    for (int i = 0; i <= int'(REG_NONCE); i++) begin
      case (fill)
        0:       value = '0;
        1:       value = '1;
        default: value = {$urandom, $urandom};
      endcase
      write_reg(reg_idx_e'(i), value);
    end
  endtask

  // Mostly long chunks that cross block boundaries, some short ones.
  task automatic queue_random(input int count);
    int left;
    int len;
    left = count;
    while (left > 0) begin
      len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 8) : $urandom_range(40, 180);
      if (len > left) len = left;
      for (int k = 0; k < len; k++) begin
        queue_word(8'($urandom_range(0, 255)),
                   (k == 0 && $urandom_range(0, 2) == 0) || $urandom_range(0, 99) == 0,
                   k == len - 1 && $urandom_range(0, 3) != 0);
      end
      left -= len;
    end
  endtask

  // The stimulus waits until every queued word has come out the far side.
  task automatic wait_drained();
    while (words_sent != words_queued || cipher_q.size() != 0) @(posedge clk_i);
  endtask

  // Driver: offers queued words with random gaps and predicts each accepted word.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i   <= 1'b0;
      data_byte_i  <= '0;
      restart_i    <= 1'b0;
      chunk_last_i <= 1'b0;
      tx_wait = 0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        next_word.data    = data_byte_i;
        next_word.restart = restart_i;
        next_word.last    = chunk_last_i;
        encrypt_byte(next_word);
        words_sent++;
        if ($urandom_range(0, 99) < 2) tx_gaps_on = !tx_gaps_on;
        tx_wait = tx_gaps_on ? $urandom_range(0, 17) : 0;
      end
      // A new word goes out only once the current one is gone and the gap is over.
      if (!in_valid_i || !in_stall_o) begin
        if (tx_wait != 0) begin
          tx_wait--;
          in_valid_i <= 1'b0;
        end else if (plain_q.size() != 0) begin
          next_word = plain_q.pop_front();
          data_byte_i  <= next_word.data;
          restart_i    <= next_word.restart;
          chunk_last_i <= next_word.last;
          in_valid_i   <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each accepted word and drives random receiver stalls.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      rx_wait = 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (cipher_q.size() == 0) begin
          $error("unexpected word: out_byte=%02h chunk_last_out=%0b",
                 out_byte_o, chunk_last_out_o);
          errors++;
        end else begin
          due_word = cipher_q.pop_front();
          if (out_byte_o !== due_word.data) begin
            $error("out_byte: expected %02h, got %02h", due_word.data, out_byte_o);
            errors++;
          end
          if (chunk_last_out_o !== due_word.last) begin
            $error("chunk_last_out: expected %0b, got %0b", due_word.last, chunk_last_out_o);
            errors++;
          end
        end
        words_taken++;
        if ($urandom_range(0, 99) < 2) rx_gaps_on = !rx_gaps_on;
        rx_wait = rx_gaps_on ? $urandom_range(0, 17) : 0;
        // One long hold-off so the block fills up and pushes back on its input.
        if (words_taken == HOLD_AT_WORD) rx_wait = HOLD_CYCLES;
      end else if (rx_wait != 0) begin
        rx_wait--;
      end
      out_stall_i <= (rx_wait != 0);
    end
  end

  // Watchdog: too long without any word moving on either side ends the run.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles == IDLE_LIMIT) begin
      $error("no word moved for %0d cycles", IDLE_LIMIT);
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Stimulus sequence.
  initial begin
    key_reg   = '{default: '0};
    nonce_reg = '0;
    blk_ctr   = '0;
    blk_pos   = '0;
    ks_words  = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // All-zero key out of reset: data extremes, chunk end, restart, both together.
    queue_word(8'h00, 1'b0, 1'b0);
    queue_word(8'hff, 1'b0, 1'b0);
    queue_word(8'h55, 1'b0, 1'b0);
    queue_word(8'haa, 1'b0, 1'b0);
    queue_word(8'h80, 1'b0, 1'b0);
    queue_word(8'h3c, 1'b0, 1'b1);
    queue_word(8'h01, 1'b0, 1'b0);
    queue_word(8'hff, 1'b1, 1'b0);
    queue_word(8'h11, 1'b1, 1'b1);
    queue_word(8'h22, 1'b0, 1'b0);
    wait_drained();

    // All-ones key and nonce; stop partway into a block.
    write_all(1);
    queue_word(8'h00, 1'b0, 1'b0);
    queue_word(8'hff, 1'b1, 1'b0);
    queue_word(8'h7e, 1'b0, 1'b0);
    wait_drained();

    // A key change mid-block must leave the current block in use.
    write_reg(REG_KEY_0_63, 64'h5555_5555_aaaa_aaaa);
    queue_word(8'h5a, 1'b0, 1'b0);
    queue_word(8'ha5, 1'b0, 1'b1);
    queue_word(8'hc3, 1'b0, 1'b0);
    queue_word(8'h0f, 1'b1, 1'b0);
    queue_word(8'hf0, 1'b0, 1'b0);
    wait_drained();

    write_all(2);
    queue_word(8'h81, 1'b1, 1'b0);
    queue_word(8'h7f, 1'b0, 1'b1);
    queue_word(8'h00, 1'b0, 1'b0);
    wait_drained();

    // Random phases that cycle through random, all-zero, all-ones and single-register settings.
    for (int p = 0; p < 8; p++) begin
      case (p % 4)
        0:       write_all(2);
        1:       write_all(0);
        2:       write_all(1);
        default: write_reg(reg_idx_e'($urandom_range(0, 4)), {$urandom, $urandom});
      endcase
      queue_random(p == 0 ? 400 : 135);
      wait_drained();
    end

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/s20_pkg.sv
rtl/s20_cfg_regs.sv
rtl/s20_core.sv
rtl/salsa20_stream_cipher_top.sv
dv/salsa20_stream_cipher_top_tb.sv
